// File: rtl/core/jtbsa_pkg.sv
package jtbsa_pkg;

   typedef enum logic [2:0] {
      ACT_CREATE   = 3'd0,
      ACT_COMPLETE = 3'd1,
      ACT_FAIL     = 3'd2,
      ACT_RELEASE  = 3'd3,
      ACT_ASSIGN   = 3'd4
   } action_type;

   localparam logic [1:0] RSP_DONE    = 2'd0;
   localparam logic [1:0] RSP_IGNORED = 2'd1;
   localparam logic [1:0] RSP_FULL    = 2'd2;
   localparam logic [1:0] RSP_NO_JOB  = 2'd3;

   localparam logic [1:0] JOB_OPEN = 2'd0;
   localparam logic [1:0] JOB_BUSY = 2'd1;
   localparam logic [1:0] JOB_DONE = 2'd2;

   typedef struct packed {
      logic [2:0]         action;
      logic [31:0]        job_id;
      logic [15:0]        agent_id;
      logic [7:0]         job_type;
      logic signed [15:0] target_x;
      logic signed [15:0] target_y;
      logic signed [15:0] priority_req;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [31:0]        result_job_id;
      logic [7:0]         result_type;
      logic signed [15:0] result_x;
      logic signed [15:0] result_y;
   } rsp_type;

   // Job record as held in the table memory.
   typedef struct packed {
      logic [31:0]        id;
      logic [7:0]         jtype;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] prio;
      logic [1:0]         state;
      logic [15:0]        holder;
   } entry_type;

endpackage

// File: rtl/core/job_table_best_score_assigner_top.sv
// Job table with best-score assignment.
// The req channel carries one command per transaction (create, complete, fail,
// release, assign); the rsp channel returns exactly one result per command.
// Both channels use valid/stall: a transaction moves on a clock edge with
// valid high and stall low.
// The table sits in one synchronous memory with a registered read port.
// Create writes the new entry when the command is taken. Complete, fail,
// release and assign walk the filled entries one per cycle (complete and fail
// stop at the first matching id; release and assign with a zero agent id are
// ignored without a walk).
// One command is in progress at a time; req_stall is high while busy or while
// a result still waits in the output register. The next command can be taken
// in the cycle after the result has gone out.
// If the receiver stalls, the result holds in the output register and no new
// command is taken until it has gone out.
// Reset is synchronous and active high; it empties the table and restarts ids
// at one. No clearing pass is needed: only entries below the fill count are
// ever read.
module job_table_best_score_assigner_top #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  jtbsa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output jtbsa_pkg::rsp_type rsp_data
);
   import jtbsa_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SCAN  = 5'b00010,
      S_WRITE = 5'b00100,
      S_FIN   = 5'b01000,
      S_OUT   = 5'b10000
   } state_type;

   entry_type mem [TABLE_DEPTH];
   entry_type rd_ff;
   logic [AW-1:0] rd_addr;
   logic          we;
   logic [AW-1:0] wa;
   entry_type     wd;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd_ff <= mem[rd_addr];
   end

   state_type     st_ff, st_in;
   req_type       cmd_ff, cmd_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [31:0]   nid_ff, nid_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          rv_ff, rv_in;
   logic [CW-1:0] ri_ff, ri_in;
   logic          found_ff, found_in;
   logic signed [19:0] bs_ff, bs_in;
   logic [AW-1:0] bi_ff, bi_in;
   entry_type     be_ff, be_in;
   rsp_type       out_ff, out_in;
   logic          ov_ff, ov_in;

   logic signed [17:0] dx, dy;
   logic signed [19:0] score;
   logic          acc;

   assign acc = req_valid && !req_stall;
   assign req_stall = (st_ff != S_IDLE) || ov_ff;
   assign rsp_valid = ov_ff;
   assign rsp_data = out_ff;

   always_comb begin
      dx = 18'(rd_ff.x) - 18'(cmd_ff.target_x);
      dy = 18'(rd_ff.y) - 18'(cmd_ff.target_y);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      score = 20'(rd_ff.prio) - (20'(dx) + 20'(dy));
   end

   always_comb begin
      st_in = st_ff; cmd_in = cmd_ff; fill_in = fill_ff; nid_in = nid_ff;
      idx_in = idx_ff; rv_in = 1'b0; ri_in = ri_ff; found_in = found_ff;
      bs_in = bs_ff; bi_in = bi_ff; be_in = be_ff; out_in = out_ff;
      ov_in = ov_ff && rsp_stall;
      we = 1'b0; wa = '0; wd = rd_ff;
      rd_addr = idx_ff[AW-1:0];
      case (st_ff)
         S_IDLE: begin
            if (acc) begin
               cmd_in = req_data;
               idx_in = '0;
               found_in = 1'b0;
               st_in = S_FIN;
               out_in = '0;
               out_in.status = RSP_IGNORED;
               case (req_data.action)
                  ACT_CREATE: begin
                     if (fill_ff == CW'(TABLE_DEPTH)) begin
                        out_in.status = RSP_FULL;
                     end else begin
                        we = 1'b1;
                        wa = fill_ff[AW-1:0];
                        wd.id = nid_ff; wd.jtype = req_data.job_type;
                        wd.x = req_data.target_x; wd.y = req_data.target_y;
                        wd.prio = req_data.priority_req;
                        wd.state = JOB_OPEN; wd.holder = '0;
                        fill_in = fill_ff + 1'b1;
                        nid_in = nid_ff + 1;
                        out_in.status = RSP_DONE;
                        out_in.result_job_id = nid_ff;
                     end
                  end
                  ACT_COMPLETE, ACT_FAIL: st_in = S_SCAN;
                  ACT_RELEASE, ACT_ASSIGN: begin
                     if (req_data.agent_id != '0) st_in = S_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         S_SCAN: begin
            // Issue reads at idx; rd_ff holds entry ri_ff when rv_ff.
            if (idx_ff < fill_ff && !(found_ff && (cmd_ff.action == ACT_COMPLETE
                  || cmd_ff.action == ACT_FAIL))) begin
               rv_in = 1'b1;
               ri_in = idx_ff;
               idx_in = idx_ff + 1'b1;
            end
            if (rv_ff) begin
               case (cmd_ff.action)
                  ACT_COMPLETE, ACT_FAIL: begin
                     if (!found_ff && rd_ff.id == cmd_ff.job_id) begin
                        found_in = 1'b1;
                        rv_in = 1'b0;
                        bi_in = ri_ff[AW-1:0];
                        be_in = rd_ff;
                     end
                  end
                  ACT_RELEASE: begin
                     if (rd_ff.holder == cmd_ff.agent_id && rd_ff.state == JOB_BUSY) begin
                        we = 1'b1; wa = ri_ff[AW-1:0];
                        wd.holder = '0; wd.state = JOB_OPEN;
                     end
                  end
                  default: begin
                     if (rd_ff.state == JOB_OPEN && (!found_ff || score > bs_ff)) begin
                        found_in = 1'b1; bs_in = score;
                        bi_in = ri_ff[AW-1:0]; be_in = rd_ff;
                     end
                  end
               endcase
            end
            if (!rv_in && !(rv_ff && rv_in)) begin
               if (!(idx_ff < fill_ff) || found_in) begin
                  if (!rv_ff || found_in || idx_ff >= fill_ff) st_in = S_WRITE;
               end
            end
         end
         S_WRITE: begin
            case (cmd_ff.action)
               ACT_COMPLETE, ACT_FAIL: begin
                  if (found_ff && (be_ff.holder == '0 || be_ff.holder == cmd_ff.agent_id)) begin
                     we = 1'b1; wa = bi_ff; wd = be_ff;
                     wd.state = (cmd_ff.action == ACT_COMPLETE) ? JOB_DONE : JOB_OPEN;
                     wd.holder = '0;
                     out_in.status = RSP_DONE;
                  end
               end
               ACT_RELEASE: out_in.status = RSP_DONE;
               default: begin
                  if (found_ff) begin
                     we = 1'b1; wa = bi_ff; wd = be_ff;
                     wd.state = JOB_BUSY; wd.holder = cmd_ff.agent_id;
                     out_in.status = RSP_DONE;
                     out_in.result_job_id = be_ff.id;
                     out_in.result_type = be_ff.jtype;
                     out_in.result_x = be_ff.x;
                     out_in.result_y = be_ff.y;
                  end else begin
                     out_in.status = RSP_NO_JOB;
                  end
               end
            endcase
            st_in = S_FIN;
         end
         S_FIN: begin
            ov_in = 1'b1;
            st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; fill_ff <= '0; nid_ff <= 32'd1;
         rv_ff <= 1'b0; ov_ff <= 1'b0; found_ff <= 1'b0; idx_ff <= '0;
      end else begin
         st_ff <= st_in; fill_ff <= fill_in; nid_ff <= nid_in;
         rv_ff <= rv_in; ov_ff <= ov_in; found_ff <= found_in; idx_ff <= idx_in;
      end
      cmd_ff <= cmd_in; ri_ff <= ri_in; bs_ff <= bs_in; bi_ff <= bi_in;
      be_ff <= be_in; out_ff <= out_in;
   end

endmodule
